// ===== rtl/tlia_pkg.sv =====
// Shared types, constants and helpers for the tilt LED indicator.
`default_nettype none
package tlia_pkg;

  localparam int TAP_COUNT = 5;
  localparam int SAMPLE_W  = 16;
  // Running sum of all taps, signed, with headroom for the tap count
  localparam int SUM_W     = SAMPLE_W + $clog2(TAP_COUNT);
  localparam int MAG_W     = SUM_W - 1;

  // Divide by five: (n * 52429) >> 18 is exact for every n below 2**18
  localparam int          RECIP_W     = 16;
  localparam logic [15:0] RECIP       = 16'd52429;
  localparam int          RECIP_SHIFT = 18;
  localparam int          PROD_W      = MAG_W + RECIP_W;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam int OFFSET_W   = 10;
  localparam int LIMIT_W    = 5;
  localparam int LED_W      = 8;
  localparam int LEVEL_W    = 5;
  localparam int ROT_W      = $clog2(LED_W);
  localparam int ROT_LSB    = 6;
  localparam int LEVEL_LSB  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam logic [LED_W-1:0]          LED_SEED       = 8'h08;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET  = -10'sd32;
  localparam logic [LIMIT_W-1:0]        LIMIT_RESET    = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_OFFSET = 1'b0,
    REG_PWM_LIMIT     = 1'b1
  } reg_index_t;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [LED_W-1:0]   led_out;
    logic [LEVEL_W-1:0] level_out;
  } out_item_t;

  // Rotate the seed pattern right by rot places
  function automatic logic [LED_W-1:0] led_rotr(input logic [ROT_W-1:0] rot);
    logic [2*LED_W-1:0] both;
    both = {LED_SEED, LED_SEED} >> rot;
    return both[LED_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tlia_tap_cell.sv =====
// One tap of the sample shift chain.
`default_nettype none
module tlia_tap_cell (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                shift,
  input  wire logic signed [tlia_pkg::SAMPLE_W-1:0] d,
  output logic signed [tlia_pkg::SAMPLE_W-1:0]      q
);
  import tlia_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tlia_div5.sv =====
// Registered divide-by-five stage, truncating toward zero.
`default_nettype none
module tlia_div5 (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [tlia_pkg::SUM_W-1:0] sum,
  output logic signed [tlia_pkg::SUM_W-1:0]      quot
);
  import tlia_pkg::*;

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic              neg_r;
  logic [QUOT_W-1:0] q;
  logic [SUM_W-1:0]  q_ext;

  // Work on the magnitude so the quotient truncates toward zero
  assign neg = sum[SUM_W-1];
  assign mag = neg ? MAG_W'(-sum) : MAG_W'(sum);

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= PROD_W'(mag) * PROD_W'(RECIP);
      neg_r <= neg;
    end
  end

  assign q     = prod[PROD_W-1 -: QUOT_W];
  assign q_ext = SUM_W'(q);
  assign quot  = neg_r ? signed'(SUM_W'(0) - q_ext) : signed'(q_ext);

endmodule
`default_nettype wire

// ===== rtl/tilt_led_indicator_with_average_top.sv =====
// Top level: sample chain, averaging pipeline and LED/PWM output stage.
//
// Usage: items enter on in_valid/in_ready. An item with cmd = sample shifts
// its reading into a chain of five tap cells and updates a running sum; an
// item with cmd = tick steps the PWM counter. Every item yields exactly one
// result on out_valid/out_ready: the new LED pattern and level for a sample,
// the PWM-driven LED byte and current level for a tick.
// The three stages are the tap chain and running sum, the divide-by-five
// multiplier register, then the output register where pattern, level and
// PWM counter are updated in item order.
// Throughput is one item per cycle while out_ready stays high; each stage
// moves when the stage after it is empty or moving, so new items keep
// entering while a result waits.
// When the receiver stalls, the pipeline fills and in_ready drops once all
// three stages hold items.
// Reset (synchronous, active high) clears the taps, sum, counter, pattern,
// level and all valid flags, and loads sample_offset = -32, pwm_limit = 16.
// Configuration writes on cfg_we take effect at once; issue them only while
// the block is idle.
`default_nettype none
module tilt_led_indicator_with_average_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire tlia_pkg::in_item_t                    in_item,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output tlia_pkg::out_item_t                        out_item,
  input  wire logic                                  cfg_we,
  input  wire logic [tlia_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tlia_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import tlia_pkg::*;

  logic signed [OFFSET_W-1:0] sample_offset;
  logic [LIMIT_W-1:0]         pwm_limit;

  logic signed [SAMPLE_W-1:0] taps [TAP_COUNT];
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_next;
  logic                       take_sample;
  logic                       accept;

  logic                       s1_valid;
  logic                       s1_cmd;
  logic                       s2_valid;
  logic                       s2_cmd;
  logic signed [SUM_W-1:0]    s2_quot;
  logic                       s2_ready;
  logic                       out_adv;

  logic [LED_W-1:0]           base_pattern;
  logic [LEVEL_W-1:0]         bright_level;
  logic [LIMIT_W-1:0]         pwm_count;

  logic signed [SUM_W-1:0]    avg;
  logic [LED_W-1:0]           pattern_next;
  logic [LEVEL_W-1:0]         level_next;
  logic [LED_W-1:0]           drive;
  logic [LIMIT_W-1:0]         pwm_count_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_offset <= OFFSET_RESET;
      pwm_limit     <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SAMPLE_OFFSET: sample_offset <= signed'(cfg_data[OFFSET_W-1:0]);
        REG_PWM_LIMIT:     pwm_limit     <= cfg_data[LIMIT_W-1:0];
        default:           ;
      endcase
    end
  end

  // Stage handshake: each stage moves when the next is empty or moving
  assign out_adv  = !out_valid || out_ready;
  assign s2_ready = !s2_valid || out_adv;
  assign in_ready = !s1_valid || s2_ready;
  assign accept   = in_valid && in_ready;
  assign take_sample = accept && (in_item.cmd == CMD_SAMPLE);

  // Tap chain: the newest sample enters cell 0, the oldest falls off the end
  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
    if (k == 0) begin : g_first
      tlia_tap_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (take_sample),
        .d     (in_item.sample),
        .q     (taps[k])
      );
    end else begin : g_rest
      tlia_tap_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (take_sample),
        .d     (taps[k-1]),
        .q     (taps[k])
      );
    end
  end

  // Running sum: add the new sample, drop the one leaving the chain
  assign sum_next = sum + SUM_W'(in_item.sample) - SUM_W'(taps[TAP_COUNT-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (take_sample) begin
      sum <= sum_next;
    end
  end

  // Stage 1 holds the item whose sum is the current running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_cmd <= in_item.cmd;
    end
    if (s2_ready) begin
      s2_cmd <= s1_cmd;
    end
  end

  tlia_div5 u_div5 (
    .clk  (clk),
    .en   (s2_ready),
    .sum  (sum),
    .quot (s2_quot)
  );

  // Output stage: pattern and level on a sample, PWM drive on a tick
  assign avg          = s2_quot + SUM_W'(sample_offset);
  assign pattern_next = led_rotr(avg[ROT_LSB +: ROT_W]);
  assign level_next   = avg[LEVEL_LSB +: LEVEL_W];
  assign drive        = (LEVEL_W'(pwm_count) < bright_level) ? (base_pattern >> 1)
                                                             : base_pattern;
  assign pwm_count_next = (pwm_count > pwm_limit) ? '0 : pwm_count + LIMIT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      base_pattern <= '0;
      bright_level <= '0;
      pwm_count    <= '0;
    end else if (out_adv) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        if (s2_cmd == CMD_SAMPLE) begin
          base_pattern <= pattern_next;
          bright_level <= level_next;
        end else begin
          pwm_count <= pwm_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid) begin
      if (s2_cmd == CMD_SAMPLE) begin
        out_item.led_out   <= pattern_next;
        out_item.level_out <= level_next;
      end else begin
        out_item.led_out   <= drive;
        out_item.level_out <= bright_level;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A full, stalled pipeline must refuse new items
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("item accepted into a full stalled pipeline");

  // A shown result always carries the level held in the output stage
  a_level_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.level_out == bright_level))
    else $error("result level differs from held brightness level");

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

// ===== verif/tilt_led_indicator_with_average_top_test.sv =====
// Testbench for the tilt LED indicator: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tilt_led_indicator_with_average_top_test;
  import tlia_pkg::*;

  localparam int PIPE_LAT        = 3;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 60;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_REPORTS     = 40;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state
  logic signed [SAMPLE_W-1:0] tap_ring [TAP_COUNT];
  int                         ring_slot;
  logic [LIMIT_W-1:0]         pwm_cnt;
  logic [LED_W-1:0]           base_leds;
  logic [LEVEL_W-1:0]         level_reg;
  logic signed [OFFSET_W-1:0] offset_reg;
  logic [LIMIT_W-1:0]         limit_reg;

  in_item_t  stim_q [$];
  out_item_t led_due [$];
  int        queued_items;
  int        accepted_items;
  int        checked_items;
  int        err_count;
  int        send_idle_pct;
  int        stall_pct;
  bit        hold_request;

  tilt_led_indicator_with_average_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predicted block by one item and return the LED byte and level it shows
  function automatic out_item_t predict_leds(input in_item_t it);
    out_item_t   res;
    int          total;
    int          avg;
    logic [31:0] bits;
    logic [2:0]  rot;
    if (it.cmd == CMD_SAMPLE) begin
      tap_ring[ring_slot] = it.sample;
      ring_slot = (ring_slot == TAP_COUNT - 1) ? 0 : ring_slot + 1;
      total = 0;
      for (int k = 0; k < TAP_COUNT; k++) total += tap_ring[k];
      // int division truncates toward zero
      avg = total / TAP_COUNT + int'(offset_reg);
      bits = avg;
      rot = bits[8:6];
      base_leds = (LED_SEED >> rot) | (LED_SEED << (4'd8 - 4'(rot)));
      level_reg = bits[5:1];
      res.led_out = base_leds;
    end else begin
      // compare before the counter advances
      res.led_out = (pwm_cnt < level_reg) ? (base_leds >> 1) : base_leds;
      pwm_cnt = (pwm_cnt > limit_reg) ? '0 : pwm_cnt + LIMIT_W'(1);
    end
    res.level_out = level_reg;
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
    in_item_t it;
    it.cmd = cmd;
    it.sample = smp;
    stim_q.push_back(it);
    queued_items++;
    wait (accepted_items == queued_items);
  endtask

  task automatic wait_drain();
    wait (accepted_items == queued_items);
    wait (checked_items == accepted_items);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic set_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == REG_SAMPLE_OFFSET) offset_reg = val;
    else limit_reg = val[LIMIT_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Input side: hold each item until taken, idle between items at random
  initial begin : drive_items
    bit holding;
    holding = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    forever begin
      @(posedge clk);
      if (!rst && in_valid && in_ready) begin
        led_due.push_back(predict_leds(in_item));
        accepted_items++;
        holding = 1'b0;
      end
      @(negedge clk);
      if (!holding) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item = stim_q.pop_front();
          in_valid = 1'b1;
          holding = 1'b1;
        end else begin
          in_valid = 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold-off on request
  initial begin : drive_ready
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : check_results
    out_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (led_due.size() == 0) begin
          report_mismatch("result with no item pending");
        end else begin
          want = led_due.pop_front();
          checked_items++;
          if (out_item.led_out !== want.led_out)
            report_mismatch($sformatf("led_out %02h, expected %02h",
                                      out_item.led_out, want.led_out));
          if (out_item.level_out !== want.level_out)
            report_mismatch($sformatf("level_out %0d, expected %0d",
                                      out_item.level_out, want.level_out));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_reset_state();
    send_item(CMD_TICK, 16'h7fff);
    send_item(CMD_TICK, 16'h8000);
    send_item(CMD_SAMPLE, 16'h0000);
  endtask

  // Full-scale readings fill and wrap the ring; ticks show the shifted pattern
  task automatic test_sample_extremes();
    repeat (5) send_item(CMD_SAMPLE, 16'h7fff);
    repeat (3) send_item(CMD_TICK, 16'h0000);
    repeat (5) send_item(CMD_SAMPLE, 16'h8000);
    repeat (3) send_item(CMD_TICK, 16'hffff);
    send_item(CMD_SAMPLE, 16'hffff);
    send_item(CMD_TICK, 16'h5555);
  endtask

  // Fill the pipeline against a stalled output, then pause until it empties
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    repeat (30) send_item($urandom_range(1) ? CMD_TICK : CMD_SAMPLE, pick_sample());
    wait_drain();
    repeat (10) send_item($urandom_range(1) ? CMD_TICK : CMD_SAMPLE, pick_sample());
  endtask

  task automatic test_random_traffic();
    int sent;
    int n_samples;
    int n_ticks;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_reg(REG_SAMPLE_OFFSET, 10'd0);
          set_reg(REG_PWM_LIMIT, 10'd31);
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          set_reg(REG_SAMPLE_OFFSET, 10'h200);
          set_reg(REG_PWM_LIMIT, 10'd1);
          send_idle_pct = 75;
          stall_pct = 0;
        end
        2: begin
          set_reg(REG_SAMPLE_OFFSET, 10'h1ff);
          set_reg(REG_PWM_LIMIT, 10'd8);
          send_idle_pct = 0;
          stall_pct = 75;
        end
        default: begin
          set_reg(REG_SAMPLE_OFFSET, 10'($urandom));
          set_reg(REG_PWM_LIMIT, 10'($urandom_range(31, 1)));
          send_idle_pct = 7;
          stall_pct = 7;
        end
      endcase
      sent = 0;
      // a few readings, then a run of ticks that sweeps the counter
      while (sent < ITEMS_PER_PHASE) begin
        n_samples = $urandom_range(5, 1);
        n_ticks = $urandom_range(36, 0);
        repeat (n_samples) send_item(CMD_SAMPLE, pick_sample());
        repeat (n_ticks) send_item(CMD_TICK, 16'($urandom));
        sent += n_samples + n_ticks;
      end
    end
  endtask

  initial begin : run_tests
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SAMPLE_OFFSET;
    cfg_data = '0;
    hold_request = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    queued_items = 0;
    accepted_items = 0;
    checked_items = 0;
    err_count = 0;
    for (int k = 0; k < TAP_COUNT; k++) tap_ring[k] = '0;
    ring_slot = 0;
    pwm_cnt = '0;
    base_leds = '0;
    level_reg = '0;
    offset_reg = OFFSET_RESET;
    limit_reg = LIMIT_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_sample_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    $display("Ran %0d items, %0d results checked, %0d mismatches.",
             accepted_items, checked_items, err_count);
    $display("Covered full-scale readings, ring wrap, offsets -512..511, PWM limits 1..31,");
    $display("and idle mixes from none to heavy on both sides with a long output stall.");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
